@@ rtl/core/qrmgs_pkg.sv @@
// -----------------------------------------------------------------------------
// qrmgs_pkg
// Shared types, constants and fixed-point helpers for the QR decomposition core.
// -----------------------------------------------------------------------------
package qrmgs_pkg;

   localparam int DEF_MAX_ROWS = 4;
   localparam int DEF_MAX_COLS = 4;
   localparam int IDX_W        = 2;
   localparam int DIM_W        = 3;
   localparam int A_W          = 32;
   localparam int S_W          = 48;
   localparam int RSP_DATA_W   = 40;

   typedef enum logic [1:0] {
      ARITH_MUL,
      ARITH_DIV,
      ARITH_SQRT
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      logic [63:0]  opa;
      logic [63:0]  opb;
   } arith_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [95:0] result;
   } arith_rsp_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_N_RD,
      ST_N_SQ,
      ST_N_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_ZERO,
      ST_D_RD,
      ST_D_GO,
      ST_D_WAIT,
      ST_J_INIT,
      ST_P_RD,
      ST_P_RD2,
      ST_P_MUL,
      ST_P_WAIT,
      ST_P_END,
      ST_U_RD,
      ST_U_MUL,
      ST_U_WAIT,
      ST_U_SUB,
      ST_J_NEXT,
      ST_O_RD,
      ST_O_LOAD,
      ST_O_WAIT
   } state_type;

   function automatic logic [47:0] mag48(input logic signed [47:0] v);
      logic [47:0] m;
      m = v[47] ? 48'(-v) : 48'(v);
      return m;
   endfunction

   function automatic logic signed [47:0] sat_mag48(input logic [80:0] m, input logic neg);
      logic big;
      big = |m[80:47];
      if (neg) begin
         return big ? 48'sh8000_0000_0000 : 48'(-m[47:0]);
      end
      return big ? 48'sh7FFF_FFFF_FFFF : 48'(m[47:0]);
   endfunction

   function automatic logic signed [47:0] mulq(input logic [95:0] p, input logic neg);
      logic [80:0] t;
      t = {1'b0, p[95:16]} + 81'(p[15]);
      return sat_mag48(t, neg);
   endfunction

   function automatic logic signed [47:0] sat48w(input logic signed [50:0] v);
      if ((&v[50:47]) || !(|v[50:47])) begin
         return v[47:0];
      end
      return v[50] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [47:0] v);
      if ((&v[47:31]) || !(|v[47:31])) begin
         return v[31:0];
      end
      return v[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

@@ rtl/core/qrmgs_ram.sv @@
// -----------------------------------------------------------------------------
// qrmgs_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module qrmgs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/qrmgs_arith.sv @@
// -----------------------------------------------------------------------------
// qrmgs_arith
// Bit-serial shared unit: 48x48 multiply, 64/32 divide, 64-bit square root.
// -----------------------------------------------------------------------------
module qrmgs_arith (
   input  logic                     clock,
   input  logic                     reset,
   input  qrmgs_pkg::arith_req_type req,
   output qrmgs_pkg::arith_rsp_type rsp
);
   import qrmgs_pkg::*;

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   arith_op_type op_ff, op_in;
   logic [95:0]  x_ff, x_in;
   logic [63:0]  y_ff, y_in;
   logic [63:0]  z_ff, z_in;
   logic [5:0]   cnt_ff, cnt_in;

   logic [48:0]  msum;
   logic [32:0]  drem;
   logic [63:0]  strial;
   logic         fin;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      fin     = 1'b0;
      msum    = x_ff[0] ? ({1'b0, x_ff[95:48]} + {1'b0, y_ff[47:0]}) : {1'b0, x_ff[95:48]};
      drem    = {y_ff[31:0], x_ff[63]};
      strial  = z_ff + x_ff[63:0];
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = '0;
         unique case (req.op)
            ARITH_MUL: begin
               x_in = {48'b0, req.opb[47:0]};
               y_in = {16'b0, req.opa[47:0]};
            end
            ARITH_DIV: begin
               x_in = {32'b0, req.opa};
               y_in = '0;
               z_in = {32'b0, req.opb[31:0]};
            end
            ARITH_SQRT: begin
               x_in = {32'b0, 64'h4000_0000_0000_0000};
               y_in = req.opa;
               z_in = '0;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         unique case (op_ff)
            ARITH_MUL: begin
               x_in = {msum, x_ff[47:1]};
               fin  = (cnt_ff == 6'd47);
            end
            ARITH_DIV: begin
               if (drem >= {1'b0, z_ff[31:0]}) begin
                  y_in = 64'(drem - {1'b0, z_ff[31:0]});
                  x_in = {32'b0, x_ff[62:0], 1'b1};
               end else begin
                  y_in = 64'(drem);
                  x_in = {32'b0, x_ff[62:0], 1'b0};
               end
               fin = (cnt_ff == 6'd63);
            end
            ARITH_SQRT: begin
               if (y_ff >= strial) begin
                  y_in = y_ff - strial;
                  z_in = (z_ff >> 1) + x_ff[63:0];
               end else begin
                  z_in = z_ff >> 1;
               end
               x_in = {32'b0, x_ff[63:0] >> 2};
               fin  = (cnt_ff == 6'd31);
            end
            default: begin
               fin = 1'b1;
            end
         endcase
         if (fin) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ARITH_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   always_comb begin
      rsp.done = done_ff;
      rsp.busy = busy_ff;
      unique case (op_ff)
         ARITH_MUL:  rsp.result = x_ff;
         ARITH_DIV:  rsp.result = {32'b0, x_ff[63:0]};
         ARITH_SQRT: rsp.result = {64'b0, z_ff[31:0]};
         default:    rsp.result = '0;
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without work");

endmodule

@@ rtl/core/qr_modified_gram_schmidt.sv @@
// -----------------------------------------------------------------------------
// qr_modified_gram_schmidt
// QR factorization of a small Q16.16 matrix by modified Gram-Schmidt.
// -----------------------------------------------------------------------------
// Usage:
//   csr_we/csr_index/csr_wdata set num_rows (index 0) and num_cols (index 1);
//   a write restarts matrix loading. Zero counts as one, above max as max.
//   req_* takes matrix elements row-major, one per cycle while req_tready.
//   After the last element req_tready drops while the column walk runs.
//   rsp_* then gives every Q entry row-major, then every R entry row-major,
//   with rsp_tlast on the final R entry. Each result is read, registered
//   and offered in turn; a stall holds the result until rsp_tready.
// Math: one shared bit-serial unit does all math. Per column i it squares
//   each row entry, takes the square root of the sum and divides each entry
//   by a nonzero root (a zero root zeroes the column); per pair i<j it
//   multiplies once per row for the dot product and once per row for the update.
// Reset: sizes return to 4x4, loading restarts, no result is pending.
// -----------------------------------------------------------------------------
module qr_modified_gram_schmidt #(
   parameter int MAX_ROWS = qrmgs_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = qrmgs_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [qrmgs_pkg::DIM_W-1:0]        csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [qrmgs_pkg::A_W-1:0]          req_tdata,   // a_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [qrmgs_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // row_index, col_index, value, zero_norm
   output logic                               rsp_tuser,   // matrix_select
   output logic                               rsp_tlast
);
   import qrmgs_pkg::*;

   localparam int QD  = MAX_ROWS * MAX_COLS;
   localparam int RD  = MAX_COLS * MAX_COLS;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int RAW = (RD > 1) ? $clog2(RD) : 1;

   function automatic logic [QAW-1:0] qaddr(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
      return QAW'(int'(r) * MAX_COLS + int'(c));
   endfunction

   function automatic logic [RAW-1:0] raddr(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
      return RAW'(int'(r) * MAX_COLS + int'(c));
   endfunction

   state_type               state_ff, state_in;
   logic [DIM_W-1:0]        rows_ff, rows_in, cols_ff, cols_in;
   logic [IDX_W-1:0]        row_ff, row_in, col_ff, col_in;
   logic [IDX_W-1:0]        i_ff, i_in, j_ff, j_in, p_ff, p_in;
   logic [63:0]             sum_ff, sum_in;
   logic [31:0]             nrm_ff, nrm_in;
   logic signed [50:0]      dot_ff, dot_in;
   logic signed [47:0]      qi_ff, qi_in, prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic                    flag_ff, flag_in;
   logic                    osel_ff, osel_in;
   logic [RD-1:0]           rvalid_ff, rvalid_in;
   logic                    ovalid_ff, ovalid_in;
   logic [RSP_DATA_W-1:0]   odata_ff, odata_in;
   logic                    ouser_ff, ouser_in;
   logic                    olast_ff, olast_in;

   logic [DIM_W-1:0]        rows_e, cols_e;
   logic                    p_last;
   logic [DIM_W-1:0]        nxt;
   logic [64:0]             acc;
   logic [47:0]             m;
   logic signed [47:0]      mq, dsat, oval;
   logic signed [48:0]      diff;
   logic [DIM_W-1:0]        olim;

   logic                    q_we, r_we;
   logic [QAW-1:0]          q_waddr, q_raddr;
   logic [RAW-1:0]          r_waddr, r_raddr;
   logic [S_W-1:0]          q_wdata, q_rdata, r_wdata, r_rdata;
   arith_req_type           areq;
   arith_rsp_type           arsp;

   qrmgs_ram #(.WIDTH(S_W), .DEPTH(QD)) u_q_ram (
      .clock (clock), .we (q_we), .waddr (q_waddr), .wdata (q_wdata),
      .raddr (q_raddr), .rdata (q_rdata)
   );

   qrmgs_ram #(.WIDTH(S_W), .DEPTH(RD)) u_r_ram (
      .clock (clock), .we (r_we), .waddr (r_waddr), .wdata (r_wdata),
      .raddr (r_raddr), .rdata (r_rdata)
   );

   qrmgs_arith u_arith (
      .clock (clock), .reset (reset), .req (areq), .rsp (arsp)
   );

   always_comb begin
      rows_e = (rows_ff == '0) ? DIM_W'(1) :
               (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
      cols_e = (cols_ff == '0) ? DIM_W'(1) :
               (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;
      p_last = ({1'b0, p_ff} == rows_e - DIM_W'(1));
   end

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      p_in      = p_ff;
      sum_in    = sum_ff;
      nrm_in    = nrm_ff;
      dot_in    = dot_ff;
      qi_in     = qi_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      flag_in   = flag_ff;
      osel_in   = osel_ff;
      rvalid_in = rvalid_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      ouser_in  = ouser_ff;
      olast_in  = olast_ff;
      q_we      = 1'b0;
      q_waddr   = qaddr(p_ff, i_ff);
      q_wdata   = '0;
      q_raddr   = qaddr(p_ff, i_ff);
      r_we      = 1'b0;
      r_waddr   = raddr(i_ff, i_ff);
      r_wdata   = '0;
      r_raddr   = raddr(row_ff, col_ff);
      areq      = '0;
      nxt       = '0;
      acc       = '0;
      m         = mag48(q_rdata);
      mq        = mulq(arsp.result, neg_ff);
      dsat      = sat48w(dot_ff);
      diff      = 49'(signed'(q_rdata)) - 49'(prod_ff);
      oval      = '0;
      olim      = osel_ff ? cols_e : rows_e;
      req_tready = (state_ff == ST_LOAD);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               q_we    = 1'b1;
               q_waddr = qaddr(row_ff, col_ff);
               q_wdata = S_W'(signed'(req_tdata));
               if (row_ff == '0 && col_ff == '0) begin
                  flag_in = 1'b0;
               end
               if ({1'b0, col_ff} == cols_e - DIM_W'(1)) begin
                  col_in = '0;
                  if ({1'b0, row_ff} == rows_e - DIM_W'(1)) begin
                     row_in    = '0;
                     rvalid_in = '0;
                     i_in      = '0;
                     p_in      = '0;
                     sum_in    = '0;
                     state_in  = ST_N_RD;
                  end else begin
                     row_in = row_ff + IDX_W'(1);
                  end
               end else begin
                  col_in = col_ff + IDX_W'(1);
               end
            end
         end
         ST_N_RD: begin
            state_in = ST_N_SQ;
         end
         ST_N_SQ: begin
            if (|m[47:32]) begin
               sum_in = '1;
               if (p_last) begin
                  state_in = ST_SQ_GO;
               end else begin
                  p_in     = p_ff + IDX_W'(1);
                  state_in = ST_N_RD;
               end
            end else begin
               areq.start = 1'b1;
               areq.op    = ARITH_MUL;
               areq.opa   = 64'(m);
               areq.opb   = 64'(m);
               state_in   = ST_N_WAIT;
            end
         end
         ST_N_WAIT: begin
            if (arsp.done) begin
               acc    = {1'b0, sum_ff} + {1'b0, arsp.result[63:0]};
               sum_in = acc[64] ? '1 : acc[63:0];
               if (p_last) begin
                  state_in = ST_SQ_GO;
               end else begin
                  p_in     = p_ff + IDX_W'(1);
                  state_in = ST_N_RD;
               end
            end
         end
         ST_SQ_GO: begin
            areq.start = 1'b1;
            areq.op    = ARITH_SQRT;
            areq.opa   = sum_ff;
            state_in   = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (arsp.done) begin
               nrm_in = arsp.result[31:0];
               p_in   = '0;
               if (arsp.result[31:0] == '0) begin
                  flag_in  = 1'b1;
                  state_in = ST_ZERO;
               end else begin
                  r_we      = 1'b1;
                  r_waddr   = raddr(i_ff, i_ff);
                  r_wdata   = S_W'(arsp.result[31:0]);
                  rvalid_in[raddr(i_ff, i_ff)] = 1'b1;
                  state_in  = ST_D_RD;
               end
            end
         end
         ST_ZERO: begin
            q_we    = 1'b1;
            q_waddr = qaddr(p_ff, i_ff);
            q_wdata = '0;
            if (p_last) begin
               state_in = ST_J_INIT;
            end else begin
               p_in = p_ff + IDX_W'(1);
            end
         end
         ST_D_RD: begin
            state_in = ST_D_GO;
         end
         ST_D_GO: begin
            neg_in     = q_rdata[47];
            areq.start = 1'b1;
            areq.op    = ARITH_DIV;
            areq.opa   = {m, 16'b0} + {33'b0, nrm_ff[31:1]};
            areq.opb   = {32'b0, nrm_ff};
            state_in   = ST_D_WAIT;
         end
         ST_D_WAIT: begin
            if (arsp.done) begin
               q_we    = 1'b1;
               q_waddr = qaddr(p_ff, i_ff);
               q_wdata = sat_mag48({17'b0, arsp.result[63:0]}, neg_ff);
               if (p_last) begin
                  state_in = ST_J_INIT;
               end else begin
                  p_in     = p_ff + IDX_W'(1);
                  state_in = ST_D_RD;
               end
            end
         end
         ST_J_INIT: begin
            nxt = {1'b0, i_ff} + DIM_W'(1);
            if (nxt < cols_e) begin
               j_in     = nxt[IDX_W-1:0];
               p_in     = '0;
               dot_in   = '0;
               state_in = ST_P_RD;
            end else begin
               row_in   = '0;
               col_in   = '0;
               osel_in  = 1'b0;
               state_in = ST_O_RD;
            end
         end
         ST_P_RD: begin
            state_in = ST_P_RD2;
         end
         ST_P_RD2: begin
            qi_in    = q_rdata;
            q_raddr  = qaddr(p_ff, j_ff);
            state_in = ST_P_MUL;
         end
         ST_P_MUL: begin
            neg_in     = qi_ff[47] ^ q_rdata[47];
            areq.start = 1'b1;
            areq.op    = ARITH_MUL;
            areq.opa   = 64'(mag48(qi_ff));
            areq.opb   = 64'(m);
            state_in   = ST_P_WAIT;
         end
         ST_P_WAIT: begin
            if (arsp.done) begin
               dot_in = dot_ff + 51'(mq);
               if (p_last) begin
                  state_in = ST_P_END;
               end else begin
                  p_in     = p_ff + IDX_W'(1);
                  state_in = ST_P_RD;
               end
            end
         end
         ST_P_END: begin
            dot_in   = 51'(dsat);
            r_we     = 1'b1;
            r_waddr  = raddr(i_ff, j_ff);
            r_wdata  = dsat;
            rvalid_in[raddr(i_ff, j_ff)] = 1'b1;
            p_in     = '0;
            state_in = ST_U_RD;
         end
         ST_U_RD: begin
            state_in = ST_U_MUL;
         end
         ST_U_MUL: begin
            neg_in     = dot_ff[50] ^ q_rdata[47];
            areq.start = 1'b1;
            areq.op    = ARITH_MUL;
            areq.opa   = 64'(mag48(dot_ff[47:0]));
            areq.opb   = 64'(m);
            state_in   = ST_U_WAIT;
         end
         ST_U_WAIT: begin
            q_raddr = qaddr(p_ff, j_ff);
            if (arsp.done) begin
               prod_in  = mq;
               state_in = ST_U_SUB;
            end
         end
         ST_U_SUB: begin
            q_we    = 1'b1;
            q_waddr = qaddr(p_ff, j_ff);
            q_wdata = sat48w(51'(diff));
            if (p_last) begin
               state_in = ST_J_NEXT;
            end else begin
               p_in     = p_ff + IDX_W'(1);
               state_in = ST_U_RD;
            end
         end
         ST_J_NEXT: begin
            nxt    = {1'b0, j_ff} + DIM_W'(1);
            p_in   = '0;
            if (nxt < cols_e) begin
               j_in     = nxt[IDX_W-1:0];
               dot_in   = '0;
               state_in = ST_P_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               sum_in   = '0;
               state_in = ST_N_RD;
            end
         end
         ST_O_RD: begin
            q_raddr  = qaddr(row_ff, col_ff);
            state_in = ST_O_LOAD;
         end
         ST_O_LOAD: begin
            if (osel_ff) begin
               oval = rvalid_ff[raddr(row_ff, col_ff)] ? r_rdata : '0;
            end else begin
               oval = q_rdata;
            end
            ovalid_in = 1'b1;
            odata_in  = {3'b0, flag_ff, sat32(oval), col_ff, row_ff};
            ouser_in  = osel_ff;
            olast_in  = osel_ff && ({1'b0, row_ff} == cols_e - DIM_W'(1)) &&
                        ({1'b0, col_ff} == cols_e - DIM_W'(1));
            state_in  = ST_O_WAIT;
         end
         ST_O_WAIT: begin
            if (rsp_tready) begin
               ovalid_in = 1'b0;
               if (olast_ff) begin
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_O_RD;
                  if ({1'b0, col_ff} == cols_e - DIM_W'(1)) begin
                     col_in = '0;
                     if ({1'b0, row_ff} == olim - DIM_W'(1)) begin
                        row_in  = '0;
                        osel_in = 1'b1;
                     end else begin
                        row_in = row_ff + IDX_W'(1);
                     end
                  end else begin
                     col_in = col_ff + IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_we) begin
         row_in = '0;
         col_in = '0;
         if (csr_index) begin
            cols_in = csr_wdata;
         end else begin
            rows_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         rows_ff   <= DIM_W'(4);
         cols_ff   <= DIM_W'(4);
         row_ff    <= '0;
         col_ff    <= '0;
         flag_ff   <= 1'b0;
         osel_ff   <= 1'b0;
         rvalid_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         flag_ff   <= flag_in;
         osel_ff   <= osel_in;
         rvalid_ff <= rvalid_in;
         ovalid_ff <= ovalid_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      p_ff     <= p_in;
      sum_ff   <= sum_in;
      nrm_ff   <= nrm_in;
      dot_ff   <= dot_in;
      qi_ff    <= qi_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
      olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid)) else $error("load while results pending");
   a_last_is_r: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser) else $error("last on a Q entry");
   a_reload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no reload after final result");
   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !arsp.busy) else $error("math unit busy while loading");

endmodule
